[hw/rtl/wfg_pkg.sv]
// Package: shared types and codes for the wait-for graph deadlock detector.
`default_nettype none
package wfg_pkg;
    localparam int NPROC      = 16;
    localparam int LABEL_BITS = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_BLOCK = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef struct packed {
        logic       operation;
        logic [3:0] waiter;
        logic [3:0] holder;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        deadlock;
        logic [3:0]  cycle_node;
        logic [15:0] waiter_label;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLK_CHK,
        S_PROP_RD,
        S_PROP_CMP,
        S_PROP_END,
        S_DFS_ROOT,
        S_DFS_RD,
        S_DFS_STEP,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic blk_check;
        logic blk_apply;
        logic prop_init;
        logic prop_read;
        logic prop_cmp;
        logic pass_init;
        logic dfs_init;
        logic dfs_root;
        logic dfs_read;
        logic dfs_step;
        logic finish_blk;
        logic finish_chk;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_check;
        logic blk_reject;
        logic prop_last;
        logic prop_changed;
        logic root_skip;
        logic roots_done;
        logic dfs_found;
        logic dfs_empty;
    } sts_t;
endpackage
`default_nettype wire

[hw/rtl/wfg_ctrl.sv]
// Controller: sequences block, label propagation and cycle search.
`default_nettype none
module wfg_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output logic                done,
    output wfg_pkg::cmd_t       cmd,
    input  wire wfg_pkg::sts_t  sts
);
    import wfg_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_BLK_CHK;
            S_BLK_CHK:
            begin
                if (sts.is_check)        state_next = S_DFS_ROOT;
                else if (sts.blk_reject) state_next = S_DONE;
                else                     state_next = S_PROP_RD;
            end
            S_PROP_RD:  state_next = S_PROP_CMP;
            S_PROP_CMP: state_next = sts.prop_last ? S_PROP_END : S_PROP_RD;
            S_PROP_END: state_next = sts.prop_changed ? S_PROP_RD : S_DONE;
            S_DFS_ROOT:
            begin
                if (sts.roots_done)     state_next = S_DONE;
                else if (!sts.root_skip) state_next = S_DFS_RD;
            end
            S_DFS_RD:   state_next = S_DFS_STEP;
            S_DFS_STEP:
            begin
                if (sts.dfs_found)      state_next = S_DONE;
                else if (sts.dfs_empty) state_next = S_DFS_ROOT;
                else                    state_next = S_DFS_RD;
            end
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
            end
            S_BLK_CHK:
            begin
                cmd.blk_check = 1'b1;
                cmd.blk_apply = !sts.is_check && !sts.blk_reject;
                cmd.prop_init = !sts.is_check && !sts.blk_reject;
                cmd.dfs_init  = sts.is_check;
            end
            S_PROP_RD:  cmd.prop_read = 1'b1;
            S_PROP_CMP: cmd.prop_cmp = 1'b1;
            S_PROP_END: cmd.pass_init = sts.prop_changed;
            S_DFS_ROOT: cmd.dfs_root = 1'b1;
            S_DFS_RD:   cmd.dfs_read = 1'b1;
            S_DFS_STEP: cmd.dfs_step = 1'b1;
            S_DONE:
            begin
                done           = 1'b1;
                cmd.finish_blk = !sts.is_check;
                cmd.finish_chk = sts.is_check;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/wfg_dp.sv]
// Datapath: edge memory, labels, marks, search stack and result register.
`default_nettype none
module wfg_dp #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_data,
    input  wire wfg_pkg::req_t req,
    input  wire wfg_pkg::cmd_t cmd,
    output wfg_pkg::sts_t      sts,
    output wfg_pkg::rsp_t      rsp
);
    import wfg_pkg::*;

    localparam int PW = (NPROC > 1) ? $clog2(NPROC) : 1;
    localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int NW = $clog2(NPROC + 1);
    localparam int SW = $clog2(NPROC + 1);
    localparam int AW = PW + DW;
    localparam logic [LABEL_BITS-1:0] LMAX = '1;

    logic [PW-1:0]          edge_mem [2**AW];
    logic [PW-1:0]          edge_q_reg;
    logic [CW-1:0]          cnt_reg   [NPROC];
    logic [LABEL_BITS-1:0]  label_reg [NPROC];
    logic [LABEL_BITS-1:0]  next_label_reg;
    logic [NPROC-1:0]       visited_reg, onpath_reg;
    logic [PW-1:0]          stk_node_reg [NPROC];
    logic [CW-1:0]          stk_pos_reg  [NPROC];
    logic [SW-1:0]          sp_reg;
    logic [4:0]             pcount_reg;
    req_t                   req_reg;
    logic [PW-1:0]          x_reg;
    logic [NW-1:0]          root_reg;
    logic [CW-1:0]          e_reg;
    logic                   changed_reg, found_reg;
    logic [PW-1:0]          found_node_reg;
    rsp_t                   rsp_reg;

    logic [NW-1:0] n_act;
    always_comb
    begin
        if (pcount_reg == 5'd0)
            n_act = NW'(1);
        else if (32'(pcount_reg) > NPROC)
            n_act = NW'(NPROC);
        else
            n_act = NW'(pcount_reg);
    end

    logic [PW-1:0] w, h;
    assign w = req_reg.waiter[PW-1:0];
    assign h = req_reg.holder[PW-1:0];
    logic bad_id;
    assign bad_id = ({1'b0, req_reg.waiter} >= 5'(n_act))
                 || ({1'b0, req_reg.holder} >= 5'(n_act));
    logic full;
    assign full = (32'(cnt_reg[w]) >= MAX_DEGREE);

    logic [LABEL_BITS-1:0] k0, k1, knew;
    always_comb
    begin
        k0 = label_reg[w];
        if (label_reg[h] > k0) k0 = label_reg[h];
        k1 = (next_label_reg > k0) ? next_label_reg : k0;
        knew = (k1 < LMAX) ? k1 + 1'b1 : LMAX;
    end

    // edge scan position for propagation
    logic x_has_edge;
    assign x_has_edge = e_reg < cnt_reg[x_reg];
    logic x_last_node;
    assign x_last_node = (NW'(x_reg) + 1'b1) >= n_act;
    logic [CW-1:0] e_inc;
    assign e_inc = e_reg + 1'b1;

    // dfs top
    logic [SW-1:0] spm1;
    assign spm1 = sp_reg - 1'b1;
    logic [PW-1:0] top_u;
    logic [CW-1:0] top_pos;
    assign top_u   = stk_node_reg[spm1[PW-1:0]];
    assign top_pos = stk_pos_reg[spm1[PW-1:0]];
    logic top_has;
    assign top_has = top_pos < cnt_reg[top_u];
    logic v_ok;
    assign v_ok = NW'(edge_q_reg) < n_act;

    logic [AW-1:0] rd_addr;
    always_comb
    begin
        if (cmd.dfs_read)
            rd_addr = {top_u, top_pos[DW-1:0]};
        else
            rd_addr = {x_reg, e_reg[DW-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.blk_apply)
            edge_mem[{w, cnt_reg[w][DW-1:0]}] <= h;
        edge_q_reg <= edge_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPROC; i++)
            begin
                cnt_reg[i]      <= '0;
                label_reg[i]    <= '0;
                stk_node_reg[i] <= '0;
                stk_pos_reg[i]  <= '0;
            end
            next_label_reg <= LABEL_BITS'(1);
            pcount_reg     <= 5'd16;
            visited_reg    <= '0;
            onpath_reg     <= '0;
            sp_reg         <= '0;
            x_reg          <= '0;
            e_reg          <= '0;
            root_reg       <= '0;
            changed_reg    <= 1'b0;
            found_reg      <= 1'b0;
            found_node_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                pcount_reg <= cfg_data;
            if (cmd.blk_apply)
            begin
                cnt_reg[w]     <= cnt_reg[w] + 1'b1;
                label_reg[w]   <= knew;
                next_label_reg <= knew;
            end
            if (cmd.prop_init || cmd.pass_init)
            begin
                x_reg       <= '0;
                e_reg       <= '0;
                changed_reg <= 1'b0;
            end
            if (cmd.prop_cmp)
            begin
                if (x_has_edge)
                begin
                    if (v_ok && label_reg[edge_q_reg] > label_reg[x_reg])
                    begin
                        label_reg[x_reg] <= label_reg[edge_q_reg];
                        changed_reg      <= 1'b1;
                    end
                end
                if (x_has_edge && e_inc < cnt_reg[x_reg])
                    e_reg <= e_inc;
                else
                begin
                    e_reg <= '0;
                    x_reg <= x_reg + 1'b1;
                end
            end
            if (cmd.dfs_init)
            begin
                visited_reg <= '0;
                onpath_reg  <= '0;
                root_reg    <= '0;
                sp_reg      <= '0;
                found_reg   <= 1'b0;
            end
            if (cmd.dfs_root && !sts.roots_done)
            begin
                root_reg <= root_reg + 1'b1;
                if (!visited_reg[root_reg[PW-1:0]])
                begin
                    visited_reg[root_reg[PW-1:0]] <= 1'b1;
                    onpath_reg[root_reg[PW-1:0]]  <= 1'b1;
                    stk_node_reg[0]               <= root_reg[PW-1:0];
                    stk_pos_reg[0]                <= '0;
                    sp_reg                        <= SW'(1);
                end
            end
            if (cmd.dfs_step)
            begin
                if (top_has)
                begin
                    stk_pos_reg[spm1[PW-1:0]] <= top_pos + 1'b1;
                    if (v_ok)
                    begin
                        if (!visited_reg[edge_q_reg])
                        begin
                            if (32'(sp_reg) < NPROC)
                            begin
                                visited_reg[edge_q_reg]     <= 1'b1;
                                onpath_reg[edge_q_reg]      <= 1'b1;
                                stk_node_reg[sp_reg[PW-1:0]] <= edge_q_reg;
                                stk_pos_reg[sp_reg[PW-1:0]]  <= '0;
                                sp_reg                      <= sp_reg + 1'b1;
                            end
                        end
                        else if (onpath_reg[edge_q_reg])
                        begin
                            found_reg      <= 1'b1;
                            found_node_reg <= edge_q_reg;
                        end
                    end
                end
                else
                begin
                    onpath_reg[top_u] <= 1'b0;
                    sp_reg            <= spm1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
        if (cmd.finish_blk)
        begin
            rsp_reg.status       <= bad_id ? ST_RANGE : (rsp_reg.status);
            rsp_reg.deadlock     <= 1'b0;
            rsp_reg.cycle_node   <= '0;
            rsp_reg.waiter_label <= (rsp_reg.status == ST_OK)
                                  ? 16'(label_reg[w]) : 16'd0;
        end
        if (cmd.blk_check)
            rsp_reg.status <= bad_id ? ST_RANGE : (full ? ST_FULL : ST_OK);
        if (cmd.finish_chk)
        begin
            rsp_reg.status       <= ST_OK;
            rsp_reg.deadlock     <= found_reg;
            rsp_reg.cycle_node   <= found_reg ? 4'(found_node_reg) : 4'd0;
            rsp_reg.waiter_label <= '0;
        end
    end

    logic stepping_found;
    assign stepping_found = top_has && v_ok && visited_reg[edge_q_reg]
                         && onpath_reg[edge_q_reg];

    always_comb
    begin
        sts.is_check     = (req_reg.operation == OP_CHECK);
        sts.blk_reject   = bad_id || full;
        sts.prop_last    = !(x_has_edge && e_inc < cnt_reg[x_reg]) && x_last_node;
        sts.prop_changed = changed_reg;
        sts.roots_done   = root_reg >= n_act;
        sts.root_skip    = visited_reg[root_reg[PW-1:0]];
        sts.dfs_found    = stepping_found;
        sts.dfs_empty    = !top_has && (sp_reg == SW'(1));
    end

    assign rsp = rsp_reg;
endmodule
`default_nettype wire

[hw/rtl/wait_for_graph_deadlock_detector_top.sv]
// Top level: wait-for graph deadlock detector.
//
// channel | signals                  | handshake
// cmd     | start, busy, req         | accepted when start && !busy
// result  | result_valid, result     | one-cycle strobe, cannot stall
// config  | cfg_we, cfg_data         | written when cfg_we
//
// A rejected block goes straight to the result. An accepted block writes its
// edge and label, then runs propagation passes over every edge of each
// process; passes repeat until labels settle. A check runs a depth-first
// search from each unvisited root id and stops at the first cycle found.
// The single edge memory read port sets the pace.
// busy drops in the strobe cycle; no clearing pass after reset.
`default_nettype none
module wait_for_graph_deadlock_detector_top #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire wfg_pkg::req_t req,
    output logic               result_valid,
    output wfg_pkg::rsp_t      result,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_data
);
    import wfg_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic done;
    logic valid_reg;

    wfg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .done(done), .cmd(cmd), .sts(sts)
    );

    wfg_dp #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .req(req), .cmd(cmd), .sts(sts), .rsp(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= done;
    end

    assign result_valid = valid_reg;
endmodule
`default_nettype wire
